/* rtl/osb_pkg.sv */
// Shared types and constants for the odd-step square-root bounds unit.
`default_nettype none

package osb_pkg;

  // Result field widths and saturation limits
  localparam int BOUND_W   = 16;
  localparam int EST_W     = 24;
  localparam int BOUND_MAX = 65535;
  localparam int EST_MAX   = 16777215;

  // Status codes
  localparam logic STS_OK    = 1'b0;
  localparam logic STS_RANGE = 1'b1;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCALE,
    OP_COARSE,
    OP_RADIX_DIV,
    OP_FINE,
    OP_DIVF_START,
    OP_RESULT
  } op_t;

  // Kind of result to be formed
  typedef enum logic [1:0] {
    RES_RANGE,
    RES_SMALL,
    RES_ROOT
  } res_t;

  typedef struct packed {
    op_t  op;
    res_t res;
  } cmd_t;

  typedef struct packed {
    logic too_big;
    logic too_small;
    logic coarse_done;
    logic fine_done;
    logic div_done;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/odd_sum_sqrt_bounds_unit.sv */
// Top level of the odd-step square-root bounds unit: controller plus datapath.
// A normal item passes through a coarse pass of large odd steps (about
//   sqrt(value*MULTIPLIER/LARGE_STEP) of them), a fine pass of refinement steps (around RADIX)
//   and the NUM_W-bit divider (40 with defaults) before out_valid.
// Values 0, 1 and above MAX_INPUT go from the input check straight to the result. One item at
//   a time; the next item is taken the cycle after the result is loaded.
// Synchronous active-high reset clears the controller and divider; no result is pending.
`default_nettype none

module odd_sum_sqrt_bounds_unit #(
  parameter int RADIX      = 10,
  parameter int LARGE_STEP = 100,
  parameter int MULTIPLIER = 10000,
  parameter int MAX_INPUT  = 65535,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [31:0]                   value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               status,
  output logic [osb_pkg::BOUND_W-1:0]        lower_num,
  output logic [osb_pkg::BOUND_W-1:0]        upper_num,
  output logic [osb_pkg::EST_W-1:0]          estimate
);

  osb_pkg::cmd_t cmd;
  osb_pkg::sts_t sts;

  osb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  osb_datapath #(
    .RADIX      (RADIX),
    .LARGE_STEP (LARGE_STEP),
    .MULTIPLIER (MULTIPLIER),
    .MAX_INPUT  (MAX_INPUT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .value     (value),
    .status    (status),
    .lower_num (lower_num),
    .upper_num (upper_num),
    .estimate  (estimate)
  );

endmodule

`default_nettype wire

/* rtl/osb_div.sv */
// Restoring divider, one quotient bit per cycle, unsigned operands.
`default_nettype none

module osb_div #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 23
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rmd;
  logic [DEN_W-1:0] dvs;
  logic [DEN_W:0]   shifted;
  logic             ge;

  // Trial subtraction of the divisor from the shifted partial remainder
  assign shifted = {rmd, quo[NUM_W-1]};
  assign ge      = shifted >= {1'b0, dvs};

  // Control: busy flag, bit counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rmd <= '0;
      dvs <= den;
      quo <= num;
    end else if (busy) begin
      if (ge) begin
        rmd <= DEN_W'(shifted - {1'b0, dvs});
      end else begin
        rmd <= DEN_W'(shifted);
      end
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

/* rtl/osb_datapath.sv */
// Datapath: scaling, odd-step search, refinement, interpolation and result registers.
`default_nettype none

module osb_datapath #(
  parameter int RADIX      = 10,
  parameter int LARGE_STEP = 100,
  parameter int MULTIPLIER = 10000,
  parameter int MAX_INPUT  = 65535,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire osb_pkg::cmd_t                 cmd,
  output osb_pkg::sts_t                      sts,
  input  wire logic [31:0]                   value,
  output logic                               status,
  output logic [osb_pkg::BOUND_W-1:0]        lower_num,
  output logic [osb_pkg::BOUND_W-1:0]        upper_num,
  output logic [osb_pkg::EST_W-1:0]          estimate
);

  // Widths follow from the parameter ranges
  localparam int VAL_W  = $clog2(MAX_INPUT + 1);
  localparam int PROD_W = VAL_W + $clog2(MULTIPLIER + 1);
  localparam int K_W    = (PROD_W + 10) / 2 + 3;
  localparam int AW     = ((PROD_W > K_W) ? PROD_W : K_W) + 2;
  localparam int NUM_W  = AW + FRAC_BITS;
  localparam int BW     = K_W + 2;
  localparam int EW     = NUM_W + 2;
  localparam int KB_W   = K_W + 17;

  // Reciprocal of the radix, exact for every odd step that fits in K_W bits
  localparam int     RL_W    = $clog2(RADIX);
  localparam int     RS      = K_W + RL_W;
  localparam longint RECIP   = ((longint'(1) << RS) + longint'(RADIX) - 1) / longint'(RADIX);
  localparam int     RECIP_W = K_W + 2;
  localparam int     KP_W    = K_W + RECIP_W;

  // Estimate for an input of one, saturated
  localparam longint EST_ONE_L = longint'(2 * LARGE_STEP) << FRAC_BITS;
  localparam logic [osb_pkg::EST_W-1:0] EST_ONE =
    (EST_ONE_L > longint'(osb_pkg::EST_MAX)) ? osb_pkg::EST_W'(osb_pkg::EST_MAX)
                                              : osb_pkg::EST_W'(EST_ONE_L);

  logic [VAL_W-1:0]        val;
  logic                    big;
  logic                    small_in;
  logic signed [AW-1:0]    rem;
  logic [K_W-1:0]          k;
  logic                    frac_neg;
  logic signed [BW-1:0]    base;

  logic [PROD_W-1:0]       prod;
  logic signed [AW-1:0]    k_ext;
  logic signed [AW-1:0]    diff;
  logic signed [AW-1:0]    sum;
  logic signed [AW-1:0]    prev;
  logic signed [AW-1:0]    neg_prev;
  logic                    pick;
  logic signed [AW-1:0]    n_sel;
  logic [AW-1:0]           n_mag;
  logic [KP_W-1:0]         kdiv_prod;
  logic [K_W-1:0]          k_div;
  logic [NUM_W-1:0]        div_num;
  logic [K_W-1:0]          div_den;
  logic                    div_start;
  logic                    div_done;
  logic [NUM_W-1:0]        div_quo;
  logic signed [EW-1:0]    base_ext;
  logic signed [EW-1:0]    frac_ext;
  logic signed [EW-1:0]    est_s;
  logic [KB_W-1:0]         kb;
  logic [KB_W-1:0]         k_lo;
  logic [KB_W-1:0]         k_hi;

  // Scaling product and step arithmetic
  assign prod     = PROD_W'(val) * PROD_W'(MULTIPLIER);
  assign k_ext    = $signed(AW'(k));
  assign diff     = rem - k_ext;
  assign sum      = rem + k_ext;

  // Odd step divided by the radix through a reciprocal multiply
  assign kdiv_prod = KP_W'(k) * KP_W'(RECIP);
  assign k_div     = K_W'(kdiv_prod >> RS);

  // Interpolation choice: which remainder lies nearer zero
  assign prev     = rem - k_ext - AW'(2);
  assign neg_prev = -prev;
  assign pick     = neg_prev < rem;
  assign n_sel    = pick ? prev : rem;
  assign n_mag    = n_sel[AW-1] ? AW'(-n_sel) : AW'(n_sel);

  // Divider: remainder magnitude by the odd step
  assign div_start = cmd.op == osb_pkg::OP_DIVF_START;
  assign div_num   = NUM_W'(n_mag) << FRAC_BITS;
  assign div_den   = k;

  osb_div #(
    .NUM_W (NUM_W),
    .DEN_W (K_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Status back to the controller
  always_comb begin
    sts.too_big     = big;
    sts.too_small   = small_in;
    sts.coarse_done = diff[AW-1];
    sts.fine_done   = (sum > AW'(0)) || (k < K_W'(2));
    sts.div_done    = div_done;
  end

  // Estimate and bound arithmetic for a normal result
  assign base_ext = EW'(base);
  assign frac_ext = (k == '0) ? '0 : $signed(EW'(div_quo));
  assign est_s    = (base_ext <<< FRAC_BITS) + (frac_neg ? -frac_ext : frac_ext);
  assign kb       = KB_W'(k);
  assign k_lo     = kb - KB_W'(1);
  assign k_hi     = kb + KB_W'(1);

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      osb_pkg::OP_LOAD: begin
        big      <= value > 32'(MAX_INPUT);
        small_in <= value < 32'd2;
        val      <= value[VAL_W-1:0];
      end
      osb_pkg::OP_SCALE: begin
        rem <= $signed(AW'(prod));
        k   <= K_W'(LARGE_STEP);
      end
      osb_pkg::OP_COARSE: begin
        rem <= diff;
        if (!diff[AW-1]) begin
          k <= k + K_W'(2 * LARGE_STEP);
        end
      end
      osb_pkg::OP_RADIX_DIV: begin
        k <= k_div + K_W'(RADIX - 1);
      end
      osb_pkg::OP_FINE: begin
        rem <= sum;
        if (!((sum > AW'(0)) || (k < K_W'(2)))) begin
          k <= k - K_W'(2);
        end
      end
      osb_pkg::OP_DIVF_START: begin
        frac_neg <= n_sel[AW-1];
        if (pick) begin
          base <= $signed(BW'(k)) + BW'(1);
        end else begin
          base <= $signed(BW'(k)) - BW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.op == osb_pkg::OP_RESULT) begin
      case (cmd.res)
        osb_pkg::RES_RANGE: begin
          status    <= osb_pkg::STS_RANGE;
          lower_num <= '0;
          upper_num <= '0;
          estimate  <= '0;
        end
        osb_pkg::RES_SMALL: begin
          status    <= osb_pkg::STS_OK;
          lower_num <= '0;
          upper_num <= osb_pkg::BOUND_W'(2 * LARGE_STEP);
          estimate  <= val[0] ? EST_ONE : '0;
        end
        default: begin
          status <= osb_pkg::STS_OK;
          if (k == '0) begin
            lower_num <= '0;
          end else if (k_lo > KB_W'(osb_pkg::BOUND_MAX)) begin
            lower_num <= osb_pkg::BOUND_W'(osb_pkg::BOUND_MAX);
          end else begin
            lower_num <= osb_pkg::BOUND_W'(k_lo);
          end
          if (k_hi > KB_W'(osb_pkg::BOUND_MAX)) begin
            upper_num <= osb_pkg::BOUND_W'(osb_pkg::BOUND_MAX);
          end else begin
            upper_num <= osb_pkg::BOUND_W'(k_hi);
          end
          if (est_s[EW-1]) begin
            estimate <= '0;
          end else if (est_s > $signed(EW'(osb_pkg::EST_MAX))) begin
            estimate <= osb_pkg::EST_W'(osb_pkg::EST_MAX);
          end else begin
            estimate <= osb_pkg::EST_W'(est_s);
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/osb_ctrl.sv */
// Controller: sequences one item through the datapath and owns both handshakes.
`default_nettype none

module osb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire osb_pkg::sts_t sts,
  output osb_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCALE,
    S_COARSE,
    S_RADIX,
    S_FINE,
    S_DIVF_GO,
    S_DIVF_WAIT,
    S_DONE
  } state_t;

  state_t        state;
  osb_pkg::res_t res_kind;
  logic          out_free;

  // Output register can take a result when empty or being drained
  assign out_free = !out_valid || !out_stall;
  assign in_stall = state != S_IDLE;

  // Datapath command for the current state
  always_comb begin
    cmd.res = res_kind;
    case (state)
      S_IDLE:      cmd.op = in_valid ? osb_pkg::OP_LOAD : osb_pkg::OP_NONE;
      S_SCALE:     cmd.op = osb_pkg::OP_SCALE;
      S_COARSE:    cmd.op = osb_pkg::OP_COARSE;
      S_RADIX:     cmd.op = osb_pkg::OP_RADIX_DIV;
      S_FINE:      cmd.op = osb_pkg::OP_FINE;
      S_DIVF_GO:   cmd.op = osb_pkg::OP_DIVF_START;
      S_DONE:      cmd.op = out_free ? osb_pkg::OP_RESULT : osb_pkg::OP_NONE;
      default:     cmd.op = osb_pkg::OP_NONE;
    endcase
  end

  // State, result kind and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_kind  <= osb_pkg::RES_ROOT;
      out_valid <= 1'b0;
    end else begin
      // a new result replaces one that is being taken
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (sts.too_big) begin
            res_kind <= osb_pkg::RES_RANGE;
            state    <= S_DONE;
          end else if (sts.too_small) begin
            res_kind <= osb_pkg::RES_SMALL;
            state    <= S_DONE;
          end else begin
            res_kind <= osb_pkg::RES_ROOT;
            state    <= S_SCALE;
          end
        end
        S_SCALE: begin
          state <= S_COARSE;
        end
        S_COARSE: begin
          if (sts.coarse_done) begin
            state <= S_RADIX;
          end
        end
        S_RADIX: begin
          state <= S_FINE;
        end
        S_FINE: begin
          if (sts.fine_done) begin
            state <= S_DIVF_GO;
          end
        end
        S_DIVF_GO: begin
          state <= S_DIVF_WAIT;
        end
        S_DIVF_WAIT: begin
          if (sts.div_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* bench/odd_sum_sqrt_bounds_unit_test.sv */
// Self-checking bench for the odd-step square-root bounds unit, with an in-bench predictor.
module odd_sum_sqrt_bounds_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import osb_pkg::*;

  localparam int RADIX       = 10;
  localparam int LARGE_STEP  = 100;
  localparam int MULTIPLIER  = 10000;
  localparam int MAX_INPUT   = 65535;
  localparam int FRAC_BITS   = 8;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN       = 40;

  typedef struct packed {
    logic               status;
    logic [BOUND_W-1:0] lower;
    logic [BOUND_W-1:0] upper;
    logic [EST_W-1:0]   est;
  } root_result_t;

  // Predicts each root result and matches it against what the block returns
  class root_bounds_board;
    root_result_t expected_roots[$];
    longint       last_remainder;
    longint       last_odd_step;
    int           mismatches;
    int           failures;

    function new();
      last_remainder = 0;
      last_odd_step  = 0;
      mismatches     = 0;
      failures       = 0;
    endfunction

    static function longint saturate(longint x, longint hi);
      if (x < 0) return 0;
      if (x > hi) return hi;
      return x;
    endfunction

    function root_result_t predict_root(logic [31:0] v);
      root_result_t r;
      longint vl, rem, k, prev, frac, est, one;
      vl  = {32'd0, v};
      one = longint'(1) << FRAC_BITS;
      r   = '0;
      // out of range: error status, no state change
      if (vl > MAX_INPUT) begin
        r.status = STS_RANGE;
        return r;
      end
      r.status = STS_OK;
      // zero and one are exact
      if (vl <= 1) begin
        r.upper = BOUND_W'(saturate(2 * LARGE_STEP, BOUND_MAX));
        r.est   = EST_W'(saturate(vl * 2 * LARGE_STEP * one, EST_MAX));
        return r;
      end
      // coarse pass: take off odd multiples of the large step
      rem = vl * MULTIPLIER;
      k   = LARGE_STEP;
      forever begin
        rem -= k;
        if (rem < 0) break;
        k += 2 * LARGE_STEP;
      end
      // fine pass: back up by odd steps falling by two
      k = k / RADIX + (RADIX - 1);
      forever begin
        rem += k;
        if (rem > 0) break;
        if (k < 2) break;
        k -= 2;
      end
      // interpolate from whichever remainder lies nearer zero
      prev = rem - (k + 2);
      if (-prev < rem) begin
        frac = (k > 0) ? (prev * one) / k : 0;
        est  = (k + 1) * one + frac;
      end else begin
        frac = (k > 0) ? (rem * one) / k : 0;
        est  = (k - 1) * one + frac;
      end
      last_remainder = rem & 64'hFFFF_FFFF;
      last_odd_step  = k & 64'hF_FFFF;
      r.lower = BOUND_W'(saturate(k - 1, BOUND_MAX));
      r.upper = BOUND_W'(saturate(k + 1, BOUND_MAX));
      r.est   = EST_W'(saturate(est, EST_MAX));
      return r;
    endfunction

    function void note_value(logic [31:0] v);
      expected_roots.push_back(predict_root(v));
    endfunction

    function void check_root(root_result_t got);
      root_result_t want;
      if (expected_roots.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d lower %0d upper %0d estimate %0d",
                   got.status, got.lower, got.upper, got.est);
        return;
      end
      want = expected_roots.pop_front();
      if (got.status !== want.status || got.lower !== want.lower ||
          got.upper !== want.upper || got.est !== want.est) begin
        failures++;
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                   want.status, want.lower, want.upper, want.est,
                   got.status, got.lower, got.upper, got.est);
      end
    endfunction

    function int pending();
      return expected_roots.size();
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [31:0]        value     = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               status;
  logic [BOUND_W-1:0] lower_num;
  logic [BOUND_W-1:0] upper_num;
  logic [EST_W-1:0]   estimate;

  root_bounds_board board;
  bit               idling     = 1'b1;
  int               stall_left = 0;
  int               cycle_count = 0;

  odd_sum_sqrt_bounds_unit #(
    .RADIX      (RADIX),
    .LARGE_STEP (LARGE_STEP),
    .MULTIPLIER (MULTIPLIER),
    .MAX_INPUT  (MAX_INPUT),
    .FRAC_BITS  (FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .lower_num (lower_num),
    .upper_num (upper_num),
    .estimate  (estimate)
  );

  always #5 clk = ~clk;

  // Cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver stalls in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if (idling && $urandom_range(0, 2) == 0) begin
      out_stall  = 1'b1;
      stall_left = $urandom_range(1, 18) - 1;
    end else begin
      out_stall = 1'b0;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_root(root_result_t'{status, lower_num, upper_num, estimate});
  end

  function automatic int pick_gap();
    if (idling && $urandom_range(0, 2) == 0) return $urandom_range(1, 18);
    return 0;
  endfunction

  // Present one item, hold it until taken, then note it
  task automatic drive_item(logic [31:0] v, int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      value    = $urandom;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    value    = v;
    do @(posedge clk); while (in_stall);
    board.note_value(v);
  endtask

  // Mostly in-range values, some small ones, the rest any 32-bit pattern
  task automatic run_random(int count);
    logic [31:0] v;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: v = $urandom_range(0, MAX_INPUT);
        6:                v = $urandom_range(0, 300);
        default:          v = $urandom;
      endcase
      drive_item(v, pick_gap());
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  logic [31:0] directed_values[$] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd16, 32'd99, 32'd100, 32'd101,
    32'd255, 32'd256, 32'd1024, 32'd10000, 32'd12345,
    32'd65534, 32'd65535, 32'd65536, 32'h0001_FFFF, 32'h8000_0000,
    32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA
  };

  initial begin
    board = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed corners: exact small values, range edges, bit patterns
    foreach (directed_values[i])
      drive_item(directed_values[i], pick_gap());

    run_random(100);
    // sender holds off until every result is back
    wait_drained();
    run_random(70);
    // closing stretch without idling
    idling = 1'b0;
    run_random(30);
    wait_drained();
    repeat (DRAIN) @(posedge clk);

    if (board.failures == 0 && board.pending() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

/* sim.f */
rtl/osb_pkg.sv
rtl/osb_div.sv
rtl/osb_datapath.sv
rtl/osb_ctrl.sv
rtl/odd_sum_sqrt_bounds_unit.sv
bench/odd_sum_sqrt_bounds_unit_test.sv
